### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset
`define PPG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppg assertion failed");
// Checked on every rising edge, reset included
`define PPG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppg assertion failed");
`else
`define PPG_ASSERT(lbl, clk, rst_n, prop)
`define PPG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Constants, coefficient tables and helpers for the piecewise GELU unit.
// ----------------------------------------------------------------------------
package ppg_pkg;

  localparam int DATA_WIDTH_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 20;
  localparam int TABLE_FRAC         = 30;
  localparam int HI_DEG             = 6;
  localparam int LO_DEG             = 3;
  localparam int CFG_IDX_W          = 2;

  // Register defaults in Q4.12
  localparam longint LOWER_BOUND_Q12 = -13853;
  localparam longint UPPER_BOUND_Q12 = 4308;
  localparam longint CUT_POINT_Q12   = -7987;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_BOUND = 2'd0,
    REG_UPPER_BOUND = 2'd1,
    REG_CUT_POINT   = 2'd2
  } cfg_reg_t;

  // Coefficient sets with 30 fraction bits, lowest order first
  localparam longint LO_SET_Q30 [0:LO_DEG] = '{
    -64'sd542672468, -64'sd453404463, -64'sd126783279, -64'sd11847811
  };
  localparam longint HI_SET_Q30 [0:HI_DEG] = '{
    64'sd9155068, 64'sd536870912, 64'sd386900607, 64'sd0,
    -64'sd40467397, 64'sd0, 64'sd1939979
  };

  // Right shift, rounding half away from zero
  function automatic longint shr_round(longint v, int k);
    longint m;
    m = (v < 0) ? -v : v;
    if (k <= 0) begin
      return v;
    end
    m = (m + (64'sd1 <<< (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  // Rescale a Q4.12 constant to xf fraction bits
  function automatic longint from_q12(longint v, int xf);
    longint r;
    r = v;
    if (xf >= 12) begin
      r = v <<< (xf - 12);
    end else begin
      r = shr_round(v, 12 - xf);
    end
    return r;
  endfunction

  function automatic longint hi_coef(int k, int frac);
    longint r;
    r = 0;
    if (k >= 0 && k <= HI_DEG) begin
      r = shr_round(HI_SET_Q30[k], TABLE_FRAC - frac);
    end
    return r;
  endfunction

  function automatic longint lo_coef(int k, int frac);
    longint r;
    r = 0;
    if (k >= 0 && k <= LO_DEG) begin
      r = shr_round(LO_SET_Q30[k], TABLE_FRAC - frac);
    end
    return r;
  endfunction

endpackage

### rtl/ppg_cell.sv
// ----------------------------------------------------------------------------
// ppg_cell
// One Horner step: acc = sat(round(acc * x) + c), registered, with handshake.
// ----------------------------------------------------------------------------
module ppg_cell #(
  parameter int DATA_WIDTH     = ppg_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ppg_pkg::COEF_FRAC_BITS_DEF,
  parameter int STEP           = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 vld_i,
  output logic                                 rdy_o,
  input  logic signed [DATA_WIDTH-1:0]         x_i,
  input  logic signed [COEF_FRAC_BITS+11:0]    acc_i,
  input  logic                                 upper_i,
  output logic                                 vld_o,
  input  logic                                 rdy_i,
  output logic signed [DATA_WIDTH-1:0]         x_o,
  output logic signed [COEF_FRAC_BITS+11:0]    acc_o,
  output logic                                 upper_o
);
  import ppg_pkg::*;

  localparam int XF = DATA_WIDTH - 4;
  localparam int AW = COEF_FRAC_BITS + 12;
  localparam int PW = AW + DATA_WIDTH;
  localparam int RW = PW - XF;
  localparam int SW = RW + 1;
  localparam logic signed [AW-1:0] C_HI = AW'(hi_coef(STEP, COEF_FRAC_BITS));
  localparam logic signed [AW-1:0] C_LO = AW'(lo_coef(STEP, COEF_FRAC_BITS));
  localparam logic LO_ACTIVE = (STEP < LO_DEG);
  localparam logic [PW-1:0] HALF = PW'(1) << (XF - 1);
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [RW-1:0] scaled;
  logic signed [AW-1:0] coef;
  logic signed [SW-1:0] sum;
  logic signed [AW-1:0] step_acc;
  logic                 load;

  logic                 vld_r,   vld_nxt;
  logic signed [DATA_WIDTH-1:0] x_r;
  logic signed [AW-1:0] acc_r,   acc_nxt;
  logic                 upper_r;

  // Round half away from zero: bias negatives down by one before the shift
  assign prod   = acc_i * x_i;
  assign rnd    = prod + HALF - {{(PW-1){1'b0}}, prod[PW-1]};
  assign scaled = rnd[PW-1:XF];
  assign coef   = upper_i ? C_HI : C_LO;
  assign sum    = SW'(scaled) + SW'(coef);

  always_comb begin
    if (sum > SW'(ACC_MAX)) begin
      step_acc = ACC_MAX;
    end else if (sum < SW'(ACC_MIN)) begin
      step_acc = ACC_MIN;
    end else begin
      step_acc = sum[AW-1:0];
    end
  end

  assign load    = !vld_r || rdy_i;
  assign rdy_o   = load;
  assign vld_nxt = load ? vld_i : vld_r;
  // The cubic set skips the higher steps: hold the accumulator there
  assign acc_nxt = (upper_i || LO_ACTIVE) ? step_acc : acc_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_i) begin
      x_r     <= x_i;
      acc_r   <= acc_nxt;
      upper_r <= upper_i;
    end
  end

  assign vld_o   = vld_r;
  assign x_o     = x_r;
  assign acc_o   = acc_r;
  assign upper_o = upper_r;

endmodule

### rtl/ppg_out.sv
// ----------------------------------------------------------------------------
// ppg_out
// Rescale the accumulator to the sample format, saturate and register.
// ----------------------------------------------------------------------------
module ppg_out #(
  parameter int DATA_WIDTH     = ppg_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ppg_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  output logic                              rdy_o,
  input  logic signed [COEF_FRAC_BITS+11:0] acc_i,
  input  logic                              upper_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_activation_out,
  output logic                              out_upper_segment
);
  import ppg_pkg::*;

  localparam int XF = DATA_WIDTH - 4;
  localparam int AW = COEF_FRAC_BITS + 12;
  localparam int YW = AW + XF + DATA_WIDTH;
  localparam logic signed [YW-1:0] YMAX = YW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [YW-1:0] YMIN = YW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  logic signed [YW-1:0]         y_wide;
  logic signed [DATA_WIDTH-1:0] y_sat;
  logic                         load;
  logic                         vld_r, vld_nxt;
  logic signed [DATA_WIDTH-1:0] y_r;
  logic                         upper_r;

  generate
    if (COEF_FRAC_BITS > XF) begin : g_shr
      localparam int SH = COEF_FRAC_BITS - XF;
      localparam logic [AW:0] HALF = (AW+1)'(1) << (SH - 1);
      logic signed [AW:0] biased;
      assign biased = (AW+1)'(acc_i) + HALF - {{AW{1'b0}}, acc_i[AW-1]};
      assign y_wide = YW'(biased >>> SH);
    end else begin : g_shl
      assign y_wide = YW'(acc_i) <<< (XF - COEF_FRAC_BITS);
    end
  endgenerate

  always_comb begin
    if (y_wide > YMAX) begin
      y_sat = YMAX[DATA_WIDTH-1:0];
    end else if (y_wide < YMIN) begin
      y_sat = YMIN[DATA_WIDTH-1:0];
    end else begin
      y_sat = y_wide[DATA_WIDTH-1:0];
    end
  end

  assign load    = !vld_r || out_ready;
  assign rdy_o   = load;
  assign vld_nxt = load ? vld_i : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_i) begin
      y_r     <= y_sat;
      upper_r <= upper_i;
    end
  end

  assign out_valid          = vld_r;
  assign out_activation_out = y_r;
  assign out_upper_segment  = upper_r;

endmodule

### rtl/piecewise_poly_gelu.sv
// A result passes through the entry register, six Horner cells and the output register.
// Throughput: one sample per cycle while out_ready is high; every stage is a registered
// cell with its own valid bit, so bubbles close up and a stall only backs up the stages
// that hold items.
// Samples outside the window give no result and leave no item in the chain.
// Reset (rst_n low, synchronous) empties every stage and loads the default window and cut point.
// ----------------------------------------------------------------------------
// piecewise_poly_gelu
// Piecewise polynomial GELU: window filter, segment select and a chain of
// Horner cells, one coefficient step per cell, then rounding and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piecewise_poly_gelu #(
  parameter int DATA_WIDTH     = ppg_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ppg_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [DATA_WIDTH-1:0]               cfg_wdata,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        in_x_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        out_activation_out,
  output logic                                out_upper_segment
);
  import ppg_pkg::*;

  localparam int XF = DATA_WIDTH - 4;
  localparam int AW = COEF_FRAC_BITS + 12;
  localparam int NC = HI_DEG;

  localparam logic signed [DATA_WIDTH-1:0] LOWER_RST = DATA_WIDTH'(from_q12(LOWER_BOUND_Q12, XF));
  localparam logic signed [DATA_WIDTH-1:0] UPPER_RST = DATA_WIDTH'(from_q12(UPPER_BOUND_Q12, XF));
  localparam logic signed [DATA_WIDTH-1:0] CUT_RST   = DATA_WIDTH'(from_q12(CUT_POINT_Q12, XF));
  // Leading coefficients seed the accumulator
  localparam logic signed [AW-1:0] HI_LEAD = AW'(hi_coef(HI_DEG, COEF_FRAC_BITS));
  localparam logic signed [AW-1:0] LO_LEAD = AW'(lo_coef(LO_DEG, COEF_FRAC_BITS));

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes are ignored
  // ---------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] lower_r, lower_nxt;
  logic signed [DATA_WIDTH-1:0] upper_r, upper_nxt;
  logic signed [DATA_WIDTH-1:0] cut_r,   cut_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    cut_nxt   = cut_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOWER_BOUND: lower_nxt = cfg_wdata;
        REG_UPPER_BOUND: upper_nxt = cfg_wdata;
        REG_CUT_POINT:   cut_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
      cut_r   <= CUT_RST;
    end else begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      cut_r   <= cut_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry stage: drop samples outside the window, pick the segment and seed
  // the accumulator with that segment's leading coefficient
  // ---------------------------------------------------------------------------
  logic                         in_win;
  logic                         in_hi;
  logic                         in_acc;
  logic                         ent_load;
  logic                         ent_vld_r, ent_vld_nxt;
  logic signed [DATA_WIDTH-1:0] ent_x_r;
  logic signed [AW-1:0]         ent_acc_r;
  logic                         ent_upper_r;

  logic                         stg_vld   [0:NC];
  logic                         stg_rdy   [0:NC];
  logic signed [DATA_WIDTH-1:0] stg_x     [0:NC];
  logic signed [AW-1:0]         stg_acc   [0:NC];
  logic                         stg_upper [0:NC];

  assign in_win   = (in_x_sample >= lower_r) && (in_x_sample <= upper_r);
  assign in_hi    = (in_x_sample >= cut_r);
  assign ent_load = !ent_vld_r || stg_rdy[0];
  assign in_ready = ent_load;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (ent_load) begin
      ent_vld_nxt = in_acc && in_win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_win) begin
      ent_x_r     <= in_x_sample;
      ent_upper_r <= in_hi;
      ent_acc_r   <= in_hi ? HI_LEAD : LO_LEAD;
    end
  end

  assign stg_vld[0]   = ent_vld_r;
  assign stg_x[0]     = ent_x_r;
  assign stg_acc[0]   = ent_acc_r;
  assign stg_upper[0] = ent_upper_r;

  // ---------------------------------------------------------------------------
  // Horner chain: cell j applies coefficient NC-1-j; the cubic set passes
  // untouched through the cells at and above its degree
  // ---------------------------------------------------------------------------
  generate
    for (genvar j = 0; j < NC; j++) begin : g_cell
      ppg_cell #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STEP           (NC - 1 - j)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_i   (stg_vld[j]),
        .rdy_o   (stg_rdy[j]),
        .x_i     (stg_x[j]),
        .acc_i   (stg_acc[j]),
        .upper_i (stg_upper[j]),
        .vld_o   (stg_vld[j+1]),
        .rdy_i   (stg_rdy[j+1]),
        .x_o     (stg_x[j+1]),
        .acc_o   (stg_acc[j+1]),
        .upper_o (stg_upper[j+1])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Output stage: round to the sample format, saturate, hold until taken
  // ---------------------------------------------------------------------------
  ppg_out #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .vld_i              (stg_vld[NC]),
    .rdy_o              (stg_rdy[NC]),
    .acc_i              (stg_acc[NC]),
    .upper_i            (stg_upper[NC]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_activation_out (out_activation_out),
    .out_upper_segment  (out_upper_segment)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PPG_ASSERT(a_win_enters, clk, rst_n, (in_acc && in_win) |=> ent_vld_r)
  `PPG_ASSERT(a_ent_holds, clk, rst_n, (ent_vld_r && !stg_rdy[0]) |=> (ent_vld_r && $stable(ent_x_r) && $stable(ent_acc_r)))
  `PPG_ASSERT(a_full_stall, clk, rst_n, (ent_vld_r && stg_vld[1] && stg_vld[NC] && out_valid && !out_ready && !stg_rdy[1]) |-> !in_ready)
  `PPG_ASSERT_ALWAYS(a_cfg_open, clk, cfg_ready)

endmodule
